>>> src/rvm_pkg.sv
// Package with shared opcodes, operand types, status codes and the decoded-instruction type.
`timescale 1ns / 1ps
package rvm_pkg;

    typedef enum logic [4:0] {
        OP_AND = 5'd0, OP_OR = 5'd1, OP_XOR = 5'd2, OP_NOT = 5'd3, OP_SHL = 5'd4,
        OP_SHR = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_MGET = 5'd9,
        OP_MPUT = 5'd10, OP_SGET = 5'd11, OP_SPUT = 5'd12, OP_LD = 5'd13,
        OP_NOP = 5'd14, OP_CALL = 5'd15, OP_EXIT = 5'd16
    } opcode_t;

    typedef enum logic [3:0] {
        OT_NONE = 4'd0, OT_RR = 4'd1, OT_RI8 = 4'd2, OT_R = 4'd3, OT_I8 = 4'd4,
        OT_I16 = 4'd5, OT_RI16 = 4'd6, OT_RI32 = 4'd7, OT_I32 = 4'd8
    } optype_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_EXIT = 2'd2;
    localparam logic [1:0] ST_HOST = 2'd3;

    localparam logic [1:0] HK_NONE = 2'd0;
    localparam logic [1:0] HK_MGET = 2'd1;
    localparam logic [1:0] HK_MPUT = 2'd2;
    localparam logic [1:0] HK_CALL = 2'd3;

    // Execution class chosen by the front end.
    typedef enum logic [2:0] {
        EX_ERR, EX_EXIT, EX_ALU, EX_SGET, EX_SPUT, EX_HOST, EX_NOP
    } exclass_t;

    // Source operand selector.
    typedef enum logic [1:0] {
        SRC_RB, SRC_IMM, SRC_IMM8, SRC_RA
    } srcsel_t;

    // One classified instruction as carried from front to back.
    typedef struct packed {
        exclass_t    cls;
        logic [4:0]  op;
        srcsel_t     src;
        logic [1:0]  words;
        logic [1:0]  host_kind;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [31:0] imm;
        logic [31:0] stream_in;
    } decoded_t;

endpackage

>>> src/rvm_front.sv
// Front end: accepts transactions and classifies opcode and operand type into a decoded record.
`timescale 1ns / 1ps
module rvm_front
    import rvm_pkg::*;
#(
    parameter int unsigned NUM_REGS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_mode,
    input  logic [3:0]  s_operand_type,
    input  logic [2:0]  s_reg_a,
    input  logic [2:0]  s_reg_b,
    input  logic [31:0] s_immediate,
    input  logic [31:0] s_stream_in,
    input  logic        s_stream_in_ok,
    output logic        q_valid,
    input  logic        q_ready,
    output decoded_t    q_data
);

    decoded_t dec;
    logic     slot_valid_reg;
    decoded_t slot_reg;

    // Reduce a register index modulo the register count by repeated compare and subtract;
    // an index below eight needs at most three steps when there are two registers.
    function automatic logic [7:0] ridx(input logic [2:0] v);
        logic [8:0] w;
        w = {6'd0, v};
        for (int i = 0; i < 4; i++) begin
            if (w >= 9'(NUM_REGS)) w = w - 9'(NUM_REGS);
        end
        return w[7:0];
    endfunction

    // Classify the instruction.
    always_comb begin
        dec           = '0;
        dec.cls       = EX_ERR;
        dec.op        = s_mode;
        dec.src       = SRC_RB;
        dec.reg_a     = ridx(s_reg_a);
        dec.reg_b     = ridx(s_reg_b);
        dec.imm       = s_immediate;
        dec.stream_in = s_stream_in;
        dec.host_kind = HK_NONE;
        dec.words     = (s_operand_type == OT_RI16 || s_operand_type == OT_RI32 ||
                         s_operand_type == OT_I32) ? 2'd2 : 2'd1;
        case (s_mode)
            OP_NOT: begin
                if (s_operand_type == OT_R) dec.cls = EX_ALU;
            end
            OP_SHL, OP_SHR: begin
                if (s_operand_type == OT_RR) begin
                    dec.cls = EX_ALU;
                end else if (s_operand_type == OT_RI8) begin
                    dec.cls = EX_ALU;
                    dec.src = SRC_IMM8;
                end
            end
            OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_LD: begin
                if (s_operand_type == OT_RR) begin
                    dec.cls = EX_ALU;
                end else if (s_operand_type == OT_RI32) begin
                    dec.cls = EX_ALU;
                    dec.src = SRC_IMM;
                end
            end
            OP_MGET, OP_MPUT: begin
                dec.host_kind = (s_mode == OP_MGET) ? HK_MGET : HK_MPUT;
                if (s_operand_type == OT_RR) begin
                    dec.cls = EX_HOST;
                end else if (s_operand_type == OT_RI32) begin
                    dec.cls = EX_HOST;
                    dec.src = SRC_IMM;
                end
            end
            OP_SGET: begin
                if (s_operand_type == OT_R && s_stream_in_ok) dec.cls = EX_SGET;
            end
            OP_SPUT: begin
                if (s_operand_type == OT_R) begin
                    dec.cls = EX_SPUT;
                    dec.src = SRC_RA;
                end else if (s_operand_type == OT_I32) begin
                    dec.cls = EX_SPUT;
                    dec.src = SRC_IMM;
                end
            end
            OP_NOP: begin
                if (s_operand_type == OT_NONE || s_operand_type == OT_I8) dec.cls = EX_NOP;
            end
            OP_CALL: begin
                dec.host_kind = HK_CALL;
                if (s_operand_type == OT_R) begin
                    dec.cls = EX_HOST;
                    dec.src = SRC_RA;
                end else if (s_operand_type == OT_I32) begin
                    dec.cls = EX_HOST;
                    dec.src = SRC_IMM;
                end
            end
            OP_EXIT: dec.cls = EX_EXIT;
            default: dec.cls = EX_ERR;
        endcase
    end

    // Single decode register; refills in the cycle it drains.
    assign s_ready = !slot_valid_reg || q_ready;
    assign q_valid = slot_valid_reg;
    assign q_data  = slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else if (s_ready) begin
            slot_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            slot_reg <= dec;
        end
    end

endmodule

>>> src/rvm_queue.sv
// Two-entry queue that decouples the front end from the execution back end.
`timescale 1ns / 1ps
module rvm_queue
    import rvm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  decoded_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output decoded_t out_data
);

    decoded_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

>>> src/rvm_back.sv
// Back end: reads regs, executes and registers one instruction a cycle unless m_ready stalls.
`timescale 1ns / 1ps
module rvm_back
    import rvm_pkg::*;
#(
    parameter int unsigned NUM_REGS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  decoded_t    q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_words_used,
    output logic        m_stream_out_valid,
    output logic [31:0] m_stream_out,
    output logic [1:0]  m_host_kind,
    output logic [31:0] m_host_addr,
    output logic [31:0] m_host_data
);

    localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [31:0] regs_reg [NUM_REGS];
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] src;
    logic [31:0] alu;
    logic        wr_en;
    logic [31:0] wr_data;
    logic        fire;
    logic        out_valid_reg;
    logic [1:0]  status_next;
    logic [1:0]  words_next;
    logic        sv_next;
    logic [31:0] sout_next;
    logic [1:0]  hk_next;
    logic [31:0] ha_next;
    logic [31:0] hd_next;
    logic [1:0]  status_reg;
    logic [1:0]  words_reg;
    logic        sv_reg;
    logic [31:0] sout_reg;
    logic [1:0]  hk_reg;
    logic [31:0] ha_reg;
    logic [31:0] hd_reg;

    assign ra = regs_reg[q_data.reg_a[IdxW-1:0]];
    assign rb = regs_reg[q_data.reg_b[IdxW-1:0]];

    // Operand selection.
    always_comb begin
        case (q_data.src)
            SRC_RB:   src = rb;
            SRC_IMM:  src = q_data.imm;
            SRC_IMM8: src = {24'd0, q_data.imm[7:0]};
            SRC_RA:   src = ra;
            default:  src = rb;
        endcase
    end

    // Arithmetic and logic unit.
    always_comb begin
        case (q_data.op)
            OP_AND:  alu = ra & src;
            OP_OR:   alu = ra | src;
            OP_XOR:  alu = ra ^ src;
            OP_NOT:  alu = ~ra;
            OP_SHL:  alu = (src[31:5] != 27'd0) ? 32'd0 : (ra << src[4:0]);
            OP_SHR:  alu = (src[31:5] != 27'd0) ? 32'd0 : (ra >> src[4:0]);
            OP_ADD:  alu = ra + src;
            OP_SUB:  alu = ra - src;
            OP_MUL:  alu = ra * src;
            default: alu = src;
        endcase
    end

    // Result fields and register write-back.
    always_comb begin
        status_next = ST_OK;
        words_next  = q_data.words;
        sv_next     = 1'b0;
        sout_next   = '0;
        hk_next     = HK_NONE;
        ha_next     = '0;
        hd_next     = '0;
        wr_en       = 1'b0;
        wr_data     = alu;
        case (q_data.cls)
            EX_ALU:  wr_en = 1'b1;
            EX_SGET: begin
                wr_en   = 1'b1;
                wr_data = q_data.stream_in;
            end
            EX_SPUT: begin
                sv_next   = 1'b1;
                sout_next = src;
            end
            EX_HOST: begin
                status_next = ST_HOST;
                hk_next     = q_data.host_kind;
                ha_next     = src;
                hd_next     = (q_data.host_kind == HK_MPUT) ? ra : 32'd0;
            end
            EX_NOP:  status_next = ST_OK;
            EX_EXIT: begin
                status_next = ST_EXIT;
                words_next  = 2'd0;
            end
            default: begin
                status_next = ST_ERR;
                words_next  = 2'd0;
            end
        endcase
    end

    // Output register drains and refills in the same cycle.
    assign q_ready = !out_valid_reg || m_ready;
    assign fire    = q_ready && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= '0;
        end else begin
            if (q_ready) out_valid_reg <= q_valid;
            if (fire && wr_en) regs_reg[q_data.reg_a[IdxW-1:0]] <= wr_data;
        end
        if (fire) begin
            status_reg <= status_next;
            words_reg  <= words_next;
            sv_reg     <= sv_next;
            sout_reg   <= sout_next;
            hk_reg     <= hk_next;
            ha_reg     <= ha_next;
            hd_reg     <= hd_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = status_reg;
    assign m_words_used       = words_reg;
    assign m_stream_out_valid = sv_reg;
    assign m_stream_out       = sout_reg;
    assign m_host_kind        = hk_reg;
    assign m_host_addr        = ha_reg;
    assign m_host_data        = hd_reg;

endmodule

>>> src/register_vm_instruction_step.sv
// Path from input acceptance to result: decode register, queue entry, execute output register.
// Throughput: one instruction per cycle while m_ready stays high; the register file is read and written in execute.
// The decode and output registers refill in the cycle that they drain; the queue takes no entry while full.
// Reset (aresetn low, synchronous) empties all stages and clears the register file to zero.
`timescale 1ns / 1ps
module register_vm_instruction_step
    import rvm_pkg::*;
#(
    parameter int unsigned NUM_REGS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_mode,
    input  logic [3:0]  s_operand_type,
    input  logic [2:0]  s_reg_a,
    input  logic [2:0]  s_reg_b,
    input  logic [31:0] s_immediate,
    input  logic [31:0] s_stream_in,
    input  logic        s_stream_in_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_words_used,
    output logic        m_stream_out_valid,
    output logic [31:0] m_stream_out,
    output logic [1:0]  m_host_kind,
    output logic [31:0] m_host_addr,
    output logic [31:0] m_host_data
);

    logic     f_valid;
    logic     f_ready;
    decoded_t f_data;
    logic     b_valid;
    logic     b_ready;
    decoded_t b_data;

    rvm_front #(.NUM_REGS(NUM_REGS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_operand_type, .s_reg_a,
        .s_reg_b, .s_immediate, .s_stream_in, .s_stream_in_ok,
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    rvm_queue u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
    );

    rvm_back #(.NUM_REGS(NUM_REGS)) u_back (
        .aclk, .aresetn, .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid, .m_ready, .m_status, .m_words_used, .m_stream_out_valid,
        .m_stream_out, .m_host_kind, .m_host_addr, .m_host_data
    );

    // An error or exit result never reports a length.
    a_stop_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ERR || m_status == ST_EXIT) |-> m_words_used == 2'd0)
        else $error("stopping result with non-zero length");

    // Host kind is set exactly for host requests.
    a_host: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == ST_HOST) == (m_host_kind != HK_NONE)))
        else $error("host kind disagrees with status");

    // A stream word is only emitted with status ok.
    a_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_out_valid |-> m_status == ST_OK)
        else $error("stream output with non-ok status");

endmodule
